/* rtl/elevator_request_scheduler_macros.svh */
// Assertion macros used by the elevator request scheduler RTL.
`ifndef ELEVATOR_REQUEST_SCHEDULER_MACROS_SVH
`define ELEVATOR_REQUEST_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must hold at every clock edge outside of reset.
`define ERS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ERS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`else

`define ERS_ASSERT_ALWAYS(label, cond)
`define ERS_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

/* rtl/ers_pkg.sv */
// Constants and codes for the elevator request scheduler.
package ers_pkg;

  localparam int FLOOR_COUNT = 64;
  localparam int LOAD_MAX    = 16;

  localparam int FLOOR_W    = 6;
  localparam int LOAD_W     = 5;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(FLOOR_COUNT - 1);
  localparam logic [LOAD_W-1:0]  LOAD_CAP  = LOAD_W'(LOAD_MAX);

  // Item operations.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AGAINST  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

endpackage

/* rtl/elevator_request_scheduler.sv */
// Elevator request scheduler: SCAN stop selection with a per-floor request tally.
// An add item passes through ADD and a rejected item through REPORT, which register the result.
// A serve item scans the pending map one floor per cycle through a shared index
// counter in SCAN, and SERVE then registers the result; an output stall holds ADD, REPORT and SERVE.
// One item is in flight at a time: in_stall stays high until the sequencer is back in IDLE.
// Reset (synchronous, rst_n low): car at floor 0 heading up, nothing pending, registers default.
module elevator_request_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ers_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input item channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [ers_pkg::FLOOR_W-1:0]   in_target_floor,
  // Result item channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ers_pkg::STATUS_W-1:0]  out_status,
  output logic [ers_pkg::FLOOR_W-1:0]   out_car_floor,
  output logic                          out_heading_down,
  output logic [ers_pkg::LOAD_W-1:0]    out_pending_load,
  output logic [ers_pkg::LOAD_W-1:0]    out_served_here
);

  import ers_pkg::*;

  // The sequencer walks each item through a few short steps. REPORT returns a
  // result that leaves the car state untouched, ADD books a request, SCAN
  // steps the shared floor index until it lands on a pending floor, and SERVE
  // retires that floor.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REPORT,
    S_ADD,
    S_SCAN,
    S_SERVE
  } state_t;

  state_t               state_r, state_nxt;

  // Configuration registers.
  logic [FLOOR_W-1:0]   lowest_r, lowest_nxt;
  logic [FLOOR_W-1:0]   highest_r, highest_nxt;
  logic [LOAD_W-1:0]    limit_r, limit_nxt;

  // Car state. A set bit in the pending map also marks the tally entry for
  // that floor as valid; a clear bit means the entry reads as zero, so the
  // tally memory never needs a clearing pass.
  logic [FLOOR_W-1:0]     car_r, car_nxt;
  logic                   down_r, down_nxt;
  logic [LOAD_W-1:0]      load_r, load_nxt;
  logic [FLOOR_COUNT-1:0] pending_map_r, pending_map_nxt;

  // Item registers and the shared scan index.
  logic [FLOOR_W-1:0]   target_r, target_nxt;
  logic [STATUS_W-1:0]  rep_status_r, rep_status_nxt;
  logic [FLOOR_W-1:0]   scan_r, scan_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [FLOOR_W-1:0]   out_car_r, out_car_nxt;
  logic                 out_down_r, out_down_nxt;
  logic [LOAD_W-1:0]    out_load_r, out_load_nxt;
  logic [LOAD_W-1:0]    out_served_r, out_served_nxt;

  // Per-floor request tally, one read and one write port, registered read.
  logic [LOAD_W-1:0]    tally_mem [FLOOR_COUNT];
  logic [LOAD_W-1:0]    tally_rd_r;
  logic [FLOOR_W-1:0]   tally_raddr;
  logic                 tally_we;
  logic [LOAD_W-1:0]    tally_wdata;

  logic                 out_free;
  logic [LOAD_W-1:0]    eff_limit;
  logic                 is_empty;
  logic                 against_dir;
  logic                 out_of_range;
  logic [LOAD_W-1:0]    tally_cur;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_car_floor    = out_car_r;
  assign out_heading_down = out_down_r;
  assign out_pending_load = out_load_r;
  assign out_served_here  = out_served_r;

  // The output register can take a new result when it is empty or draining now.
  assign out_free  = !out_valid_r || !out_stall;

  // A limit above the car capacity is clamped to the capacity.
  assign eff_limit = (limit_r > LOAD_CAP) ? LOAD_CAP : limit_r;

  // Every pending floor holds at least one request, so a zero load means an
  // empty pending map.
  assign is_empty  = (load_r == '0);

  // A request for the car's own floor is never against the direction.
  assign against_dir = (!down_r && (in_target_floor < car_r)) ||
                       (down_r && (in_target_floor > car_r));

  assign out_of_range = (int'(in_target_floor) >= FLOOR_COUNT) ||
                        (in_target_floor > highest_r) ||
                        (in_target_floor < lowest_r);

  // A tally entry whose floor is not pending is stale and counts as zero.
  assign tally_cur = pending_map_r[target_r] ? tally_rd_r : '0;

  // The read address follows the item: the incoming floor while idle, the
  // scan index while scanning, and the latched floor afterwards.
  always_comb begin
    case (state_r)
      S_IDLE:  tally_raddr = in_target_floor;
      S_SCAN:  tally_raddr = scan_r;
      default: tally_raddr = target_r;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    lowest_nxt      = lowest_r;
    highest_nxt     = highest_r;
    limit_nxt       = limit_r;
    car_nxt         = car_r;
    down_nxt        = down_r;
    load_nxt        = load_r;
    pending_map_nxt = pending_map_r;
    target_nxt      = target_r;
    rep_status_nxt  = rep_status_r;
    scan_nxt        = scan_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_car_nxt     = out_car_r;
    out_down_nxt    = out_down_r;
    out_load_nxt    = out_load_r;
    out_served_nxt  = out_served_r;
    tally_we        = 1'b0;
    tally_wdata     = tally_cur + LOAD_W'(1);

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOWEST:  lowest_nxt  = cfg_wdata[FLOOR_W-1:0];
        CFG_HIGHEST: highest_nxt = cfg_wdata[FLOOR_W-1:0];
        CFG_LIMIT:   limit_nxt   = cfg_wdata[LOAD_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          target_nxt = in_target_floor;
          if (in_operation == OP_SERVE) begin
            if (is_empty) begin
              rep_status_nxt = ST_IDLE;
              state_nxt      = S_REPORT;
            end else begin
              // Heading up looks for the lowest pending floor, heading down
              // for the highest.
              scan_nxt  = down_r ? FLOOR_TOP : '0;
              state_nxt = S_SCAN;
            end
          end else if (load_r >= eff_limit) begin
            rep_status_nxt = ST_FULL;
            state_nxt      = S_REPORT;
          end else if (!is_empty && against_dir) begin
            rep_status_nxt = ST_AGAINST;
            state_nxt      = S_REPORT;
          end else if (out_of_range) begin
            rep_status_nxt = ST_RANGE;
            state_nxt      = S_REPORT;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end

      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rep_status_r;
          out_car_nxt    = car_r;
          out_down_nxt   = down_r;
          out_load_nxt   = load_r;
          out_served_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_ADD: begin
        if (out_free) begin
          tally_we                  = 1'b1;
          pending_map_nxt[target_r] = 1'b1;
          load_nxt                  = load_r + LOAD_W'(1);
          // With nothing pending the car turns toward the new request.
          if (is_empty) begin
            if (target_r > car_r) begin
              down_nxt = 1'b0;
            end else if (target_r < car_r) begin
              down_nxt = 1'b1;
            end
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ACCEPTED;
          out_car_nxt    = car_r;
          out_down_nxt   = down_nxt;
          out_load_nxt   = load_nxt;
          out_served_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_SCAN: begin
        if (pending_map_r[scan_r]) begin
          target_nxt = scan_r;
          state_nxt  = S_SERVE;
        end else if (down_r) begin
          scan_nxt = scan_r - FLOOR_W'(1);
        end else begin
          scan_nxt = scan_r + FLOOR_W'(1);
        end
      end

      S_SERVE: begin
        if (out_free) begin
          pending_map_nxt[target_r] = 1'b0;
          car_nxt  = target_r;
          load_nxt = (tally_cur > load_r) ? '0 : (load_r - tally_cur);
          // The car turns around at the ends of the configured range.
          if (target_r == highest_r) begin
            down_nxt = 1'b1;
          end else if (target_r == lowest_r) begin
            down_nxt = 1'b0;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_SERVED;
          out_car_nxt    = target_r;
          out_down_nxt   = down_nxt;
          out_load_nxt   = load_nxt;
          out_served_nxt = tally_cur;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      lowest_r      <= '0;
      highest_r     <= FLOOR_W'(63);
      limit_r       <= LOAD_W'(16);
      car_r         <= '0;
      down_r        <= 1'b0;
      load_r        <= '0;
      pending_map_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      lowest_r      <= lowest_nxt;
      highest_r     <= highest_nxt;
      limit_r       <= limit_nxt;
      car_r         <= car_nxt;
      down_r        <= down_nxt;
      load_r        <= load_nxt;
      pending_map_r <= pending_map_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    target_r     <= target_nxt;
    rep_status_r <= rep_status_nxt;
    scan_r       <= scan_nxt;
    out_status_r <= out_status_nxt;
    out_car_r    <= out_car_nxt;
    out_down_r   <= out_down_nxt;
    out_load_r   <= out_load_nxt;
    out_served_r <= out_served_nxt;
  end

  always_ff @(posedge clk) begin
    if (tally_we) begin
      tally_mem[target_r] <= tally_wdata;
    end
    tally_rd_r <= tally_mem[tally_raddr];
  end

  `include "elevator_request_scheduler_macros.svh"

  // The load and the pending map must agree on whether anything is pending.
  `ERS_ASSERT_ALWAYS(a_load_matches_map, ((load_r == '0) == (pending_map_r == '0)))
  // The load never exceeds the car capacity.
  `ERS_ASSERT_ALWAYS(a_load_capped, (load_r <= LOAD_CAP))
  // A scan only runs while some floor is pending, so it always finds a stop.
  `ERS_ASSERT_IMPLY(a_scan_has_stop, (state_r == S_SCAN), (pending_map_r != '0))
  // A served stop always clears at least one request.
  `ERS_ASSERT_IMPLY(a_served_nonzero, (out_valid_r && (out_status_r == ST_SERVED)),
                    (out_served_r != '0))

endmodule

/* sim/elevator_request_scheduler_tb.sv */
// Self-checking testbench for the elevator request scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module elevator_request_scheduler_tb;
  import ers_pkg::*;

  // Run sizing. The cycle limit sits far above the slowest legal run: every
  // serve item scanning the whole map, every gap and stall at its longest.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  // After the last result we keep watching for stray results for longer than
  // the slowest serve item takes.
  localparam int DRAIN_CYCLES    = 80;

  // One result item, in the same field order as the output ports.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FLOOR_W-1:0]  car_floor;
    logic                heading_down;
    logic [LOAD_W-1:0]   pending_load;
    logic [LOAD_W-1:0]   served_here;
  } stop_report_t;

  localparam stop_report_t NO_REPORT = '0;

  // A row of the directed table is either an item or a register write.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   op;
    logic [FLOOR_W-1:0]     floor_no;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   typed;
    stop_report_t           want;
  } plan_row_t;

  // How the result side behaves over a stretch of cycles.
  typedef enum int {SINK_READY, SINK_SPARSE, SINK_BUSY, SINK_TOGGLE} sink_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_operation;
  logic [FLOOR_W-1:0]     in_target_floor;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    out_status;
  logic [FLOOR_W-1:0]     out_car_floor;
  logic                   out_heading_down;
  logic [LOAD_W-1:0]      out_pending_load;
  logic [LOAD_W-1:0]      out_served_here;

  // Side information that travels with the item on the input port: whether
  // the expected result was typed into the table, and if so what it is.
  logic                   item_typed;
  stop_report_t           item_want;

  // Our own copy of the scheduler: configuration and car state.
  logic [FLOOR_W-1:0]     floor_min;
  logic [FLOOR_W-1:0]     floor_max;
  logic [LOAD_W-1:0]      load_cap_cfg;
  logic [FLOOR_W-1:0]     car_at;
  logic                   heading_dn;
  logic [LOAD_W-1:0]      load_now;
  logic [FLOOR_COUNT-1:0] calls_map;
  logic [LOAD_W-1:0]      calls_per_floor [FLOOR_COUNT];

  // Results still owed by the block, oldest first.
  stop_report_t           reports_due [$];

  int                     mismatches = 0;
  int                     cycle_count = 0;
  bit                     hold_off_due = 1'b0;

  // Directed table. Rows with typed set carry a result that follows at a
  // glance from the state; the rest are checked against the predictor.
  plan_row_t directed_plan [0:34] = '{
    // Fresh from reset: nothing pending, so a serve reports idle at floor 0.
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b1, '{ST_IDLE, 6'd0, 1'b0, 5'd0, 5'd0}},
    // Own floor twice, both ends, one in the middle.
    '{ROW_ITEM, OP_ADD,   6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd63, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd63, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd30, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    // Car at 30 heading up with floor 63 still pending: floor 10 is behind it.
    '{ROW_ITEM, OP_ADD,   6'd10, CFG_LOWEST,  6'd0,  1'b1, '{ST_AGAINST, 6'd30, 1'b0, 5'd2, 5'd0}},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    // Nothing pending and the request names the car's floor: direction stays.
    '{ROW_ITEM, OP_ADD,   6'd63, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd20, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd63, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    // Narrow the range to 25..40; the car now sits at 20 heading down.
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LOWEST,  6'd25, 1'b0, NO_REPORT},
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_HIGHEST, 6'd40, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd10, CFG_LOWEST,  6'd0,  1'b1, '{ST_RANGE, 6'd20, 1'b1, 5'd0, 5'd0}},
    '{ROW_ITEM, OP_ADD,   6'd50, CFG_LOWEST,  6'd0,  1'b1, '{ST_RANGE, 6'd20, 1'b1, 5'd0, 5'd0}},
    // Writing 32 to the limit drops the top bit, leaving zero: always full.
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LIMIT,   6'd32, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd30, CFG_LOWEST,  6'd0,  1'b1, '{ST_FULL, 6'd20, 1'b1, 5'd0, 5'd0}},
    // Inverted range: lowest above highest rejects every floor.
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LIMIT,   6'd1,  1'b0, NO_REPORT},
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LOWEST,  6'd40, 1'b0, NO_REPORT},
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_HIGHEST, 6'd10, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd30, CFG_LOWEST,  6'd0,  1'b1, '{ST_RANGE, 6'd20, 1'b1, 5'd0, 5'd0}},
    // Full range again; a limit of 63 keeps 31, which caps at the maximum load.
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_HIGHEST, 6'd63, 1'b0, NO_REPORT},
    '{ROW_REG,  OP_ADD,   6'd0,  CFG_LIMIT,   6'd63, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd63, CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ADD,   6'd10, CFG_LOWEST,  6'd0,  1'b1, '{ST_AGAINST, 6'd20, 1'b0, 5'd1, 5'd0}},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b1, '{ST_IDLE, 6'd63, 1'b1, 5'd0, 5'd0}},
    '{ROW_ITEM, OP_ADD,   6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT},
    '{ROW_ITEM, OP_SERVE, 6'd0,  CFG_LOWEST,  6'd0,  1'b0, NO_REPORT}
  };

  elevator_request_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_target_floor  (in_target_floor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_car_floor    (out_car_floor),
    .out_heading_down (out_heading_down),
    .out_pending_load (out_pending_load),
    .out_served_here  (out_served_here)
  );

  always #5 clk = ~clk;

  // Applies one item to the predicted car state and returns the result the
  // block should give for it.
  task automatic advance_car(input logic op, input logic [FLOOR_W-1:0] target,
                             output stop_report_t rep);
    int                 cap;
    bit                 empty;
    bit                 found;
    logic [FLOOR_W-1:0] stop;
    logic [LOAD_W-1:0]  cleared;
    begin
      rep = '0;
      cleared = '0;
      if (op == OP_ADD) begin
        // A limit above the maximum load behaves as the maximum.
        cap = (int'(load_cap_cfg) > LOAD_MAX) ? LOAD_MAX : int'(load_cap_cfg);
        empty = (calls_map == '0);
        // The checks run in a fixed order: full, then direction, then range.
        if (int'(load_now) >= cap) begin
          rep.status = ST_FULL;
        end else if (!empty && ((!heading_dn && target < car_at) ||
                                (heading_dn && target > car_at))) begin
          rep.status = ST_AGAINST;
        end else if (target > floor_max || target < floor_min) begin
          rep.status = ST_RANGE;
        end else begin
          // With nothing pending, the car turns toward the new floor.
          if (empty && target > car_at) begin
            heading_dn = 1'b0;
          end else if (empty && target < car_at) begin
            heading_dn = 1'b1;
          end
          calls_per_floor[target] = calls_per_floor[target] + LOAD_W'(1);
          calls_map[target] = 1'b1;
          load_now = load_now + LOAD_W'(1);
          rep.status = ST_ACCEPTED;
        end
      end else begin
        // Going up the first pending floor wins; going down the last one does.
        found = 1'b0;
        stop = '0;
        for (int f = 0; f < FLOOR_COUNT; f++) begin
          if (calls_map[FLOOR_W'(f)] && (!found || heading_dn)) begin
            stop = FLOOR_W'(f);
            found = 1'b1;
          end
        end
        if (!found) begin
          rep.status = ST_IDLE;
        end else begin
          car_at = stop;
          cleared = calls_per_floor[stop];
          calls_per_floor[stop] = '0;
          calls_map[stop] = 1'b0;
          load_now = (cleared > load_now) ? '0 : load_now - cleared;
          if (car_at == floor_max) begin
            heading_dn = 1'b1;
          end else if (car_at == floor_min) begin
            heading_dn = 1'b0;
          end
          rep.status = ST_SERVED;
        end
      end
      rep.car_floor    = car_at;
      rep.heading_down = heading_dn;
      rep.pending_load = load_now;
      rep.served_here  = cleared;
    end
  endtask

  // Offers one item and returns at the edge where the block takes it. The
  // payload is held until then.
  task automatic offer_item(input logic op, input logic [FLOOR_W-1:0] target,
                            input logic typed, input stop_report_t want);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_target_floor <= target;
    item_typed      <= typed;
    item_want       <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Withdraws the input and waits until every owed result has come back.
  // Each item gives exactly one result, so the block is idle afterwards.
  task automatic settle_outstanding();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Writes one register and mirrors it into the predictor, dropping the bits
  // above the register's width as the block does.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LOWEST:  floor_min = val[FLOOR_W-1:0];
      CFG_HIGHEST: floor_max = val[FLOOR_W-1:0];
      CFG_LIMIT:   load_cap_cfg = val[LOAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Both handshakes are observed here at the rising edge. Results are
  // checked before the new item is predicted; a result taken at the same
  // edge always belongs to an older item, so the order is only cosmetic.
  always @(posedge clk) begin : scoreboard
    stop_report_t got;
    stop_report_t want;
    stop_report_t rep;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status       = out_status;
        got.car_floor    = out_car_floor;
        got.heading_down = out_heading_down;
        got.pending_load = out_pending_load;
        got.served_here  = out_served_here;
        if (reports_due.size() == 0) begin
          $error("result with no item outstanding: status %0d", got.status);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.car_floor !== want.car_floor) begin
            $error("car_floor: expected %0d, got %0d", want.car_floor, got.car_floor);
            mismatches++;
          end
          if (got.heading_down !== want.heading_down) begin
            $error("heading_down: expected %0d, got %0d",
                   want.heading_down, got.heading_down);
            mismatches++;
          end
          if (got.pending_load !== want.pending_load) begin
            $error("pending_load: expected %0d, got %0d",
                   want.pending_load, got.pending_load);
            mismatches++;
          end
          if (got.served_here !== want.served_here) begin
            $error("served_here: expected %0d, got %0d",
                   want.served_here, got.served_here);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        // The predictor always runs so that its state keeps pace; a typed
        // table entry, where present, is what the result is held against.
        advance_car(in_operation, in_target_floor, rep);
        reports_due.push_back(item_typed ? item_want : rep);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. It changes its stall behavior at random intervals and,
  // once asked, holds off for a long stretch so that the block backs up and
  // stalls its input while the sender keeps offering items.
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = sink_mode_t'($urandom_range(3, 0));
      span = $urandom_range(60, 1);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          SINK_READY:  out_stall <= 1'b0;
          SINK_SPARSE: out_stall <= ($urandom_range(3, 0) == 0);
          SINK_BUSY:   out_stall <= ($urandom_range(3, 0) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Input side: reset, the directed table, then the random phases.
  initial begin : item_source
    plan_row_t          row;
    logic               op;
    logic [FLOOR_W-1:0] target;
    int                 burst;
    int                 serve_pct;
    int                 sent;
    int                 lo;
    int                 hi;
    int                 lim;
    int                 span_lo;
    int                 span_hi;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_LOWEST;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_operation    = OP_ADD;
    in_target_floor = '0;
    item_typed      = 1'b0;
    item_want       = NO_REPORT;

    // The predictor starts where the block's reset leaves it.
    floor_min    = '0;
    floor_max    = FLOOR_TOP;
    load_cap_cfg = LOAD_CAP;
    car_at       = '0;
    heading_dn   = 1'b0;
    load_now     = '0;
    calls_map    = '0;
    foreach (calls_per_floor[f]) calls_per_floor[f] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register rows wait for the block to go idle before they are written.
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_REG) begin
        settle_outstanding();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_item(row.op, row.floor_no, row.typed, row.want);
        pause_sender($urandom_range(2, 0));
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // Fixed settings cover the extremes; the last two phases are drawn.
      case (phase)
        0:       begin lo = 0;  hi = 63; lim = 63; end
        1:       begin lo = 10; hi = 50; lim = 4;  end
        2:       begin lo = 0;  hi = 0;  lim = 16; end
        3:       begin lo = 63; hi = 63; lim = 2;  end
        4:       begin lo = 20; hi = 12; lim = 8;  end
        5:       begin lo = 5;  hi = 58; lim = 17; end
        default: begin
          lo  = $urandom_range(40, 0);
          hi  = $urandom_range(63, lo);
          lim = $urandom_range(20, 1);
        end
      endcase
      settle_outstanding();
      write_reg(CFG_LOWEST, CFG_DATA_W'(lo));
      write_reg(CFG_HIGHEST, CFG_DATA_W'(hi));
      write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
      if (phase == 0) hold_off_due = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Each burst has its own mix, so some bursts pile requests up to the
        // load limit and others mostly drain them.
        burst = $urandom_range(24, 1);
        serve_pct = $urandom_range(50, 5);
        repeat (burst) begin
          target = FLOOR_W'($urandom_range(FLOOR_COUNT - 1, 0));
          if ($urandom_range(99, 0) < serve_pct) begin
            op = OP_SERVE;
          end else begin
            op = OP_ADD;
            // Most requests are legal ones: in range and ahead of the car.
            // The rest keep the fully random floor.
            if ($urandom_range(4, 0) != 0) begin
              span_lo = int'(floor_min);
              span_hi = int'(floor_max);
              if (!heading_dn && int'(car_at) > span_lo) span_lo = int'(car_at);
              if (heading_dn && int'(car_at) < span_hi) span_hi = int'(car_at);
              if (span_lo <= span_hi) target = FLOOR_W'($urandom_range(span_hi, span_lo));
            end
          end
          offer_item(op, target, 1'b0, NO_REPORT);
          sent++;
        end
        if ($urandom_range(3, 0) != 0) pause_sender($urandom_range(8, 1));
      end
    end

    settle_outstanding();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ers_pkg.sv
rtl/elevator_request_scheduler.sv
sim/elevator_request_scheduler_tb.sv
